@@ sv/qreb_pkg.sv @@
// Shared types, constants and the quadrature step table for the encoder decoder.
`timescale 1ns / 1ps

package qreb_pkg;

  localparam int LANES_DEF = 4;
  localparam int PIN_LANES = 4;
  localparam int CNT_W = 16;
  localparam int TIME_W = 32;
  localparam int DEB_W = 16;
  localparam int STATE_W = 6;
  localparam int STEP_W = 4;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd50;

  localparam logic [STATE_W-1:0] ST_START = 6'h00;
  localparam logic [STATE_W-1:0] EVENT_MASK = 6'h30;
  localparam logic [STATE_W-1:0] EV_CW = 6'h10;
  localparam logic [STATE_W-1:0] EV_CCW = 6'h20;
  localparam logic [STEP_W-1:0] STEP_MASK = 4'hf;

  // Input word: right[3:0], left[7:4], button[11:8], now_ms[43:12], pad to 48.
  localparam int IN_RIGHT_LSB = 0;
  localparam int IN_LEFT_LSB = IN_RIGHT_LSB + PIN_LANES;
  localparam int IN_BTN_LSB = IN_LEFT_LSB + PIN_LANES;
  localparam int IN_NOW_LSB = IN_BTN_LSB + PIN_LANES;
  localparam int IN_USED_W = IN_NOW_LSB + TIME_W;
  localparam int IN_W = ((IN_USED_W + 7) / 8) * 8;

  // Output word: spin counts, pressed mask, hold times, pad to whole bytes.
  localparam int OUT_CNT_LSB = 0;
  localparam int OUT_MASK_LSB = OUT_CNT_LSB + PIN_LANES * CNT_W;
  localparam int OUT_HOLD_LSB = OUT_MASK_LSB + PIN_LANES;
  localparam int OUT_USED_W = OUT_HOLD_LSB + PIN_LANES * TIME_W;
  localparam int OUT_W = ((OUT_USED_W + 7) / 8) * 8;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic held;
    logic [TIME_W-1:0] hold;
  } lane_status_t;

  // Full-step table; rows past the last valid step fall back to the start row.
  function automatic logic [STATE_W-1:0] step_lookup(input logic [STEP_W-1:0] row,
                                                      input logic [1:0] pin);
    logic [STATE_W-1:0] r0, r1, r2, r3;
    r0 = 6'h00; r1 = 6'h00; r2 = 6'h00; r3 = 6'h00;
    unique case (row)
      4'd1: begin r0 = 6'h03; r1 = 6'h00; r2 = 6'h01; r3 = 6'h10; end
      4'd2: begin r0 = 6'h03; r1 = 6'h02; r2 = 6'h00; r3 = 6'h00; end
      4'd3: begin r0 = 6'h03; r1 = 6'h02; r2 = 6'h01; r3 = 6'h00; end
      4'd4: begin r0 = 6'h06; r1 = 6'h00; r2 = 6'h04; r3 = 6'h00; end
      4'd5: begin r0 = 6'h06; r1 = 6'h05; r2 = 6'h00; r3 = 6'h20; end
      4'd6: begin r0 = 6'h06; r1 = 6'h05; r2 = 6'h04; r3 = 6'h00; end
      default: begin r0 = 6'h00; r1 = 6'h02; r2 = 6'h04; r3 = 6'h00; end
    endcase
    unique case (pin)
      2'd0: step_lookup = r0;
      2'd1: step_lookup = r1;
      2'd2: step_lookup = r2;
      default: step_lookup = r3;
    endcase
  endfunction

endpackage

@@ sv/qreb_lane.sv @@
// One encoder lane: quadrature step table, detent counter and button hold timer.
`timescale 1ns / 1ps

module qreb_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        right_pin,
  input  logic                        left_pin,
  input  logic                        button_pin,
  input  logic [qreb_pkg::TIME_W-1:0] now_ms,
  input  logic [qreb_pkg::DEB_W-1:0]  release_debounce_ms,
  output qreb_pkg::lane_status_t      status_next
);
  import qreb_pkg::*;

  logic [STATE_W-1:0] qstate, qstate_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               held, held_next;
  logic [TIME_W-1:0]  last_press, last_press_next;
  logic [TIME_W-1:0]  hold, hold_next;
  logic [TIME_W-1:0]  release_edge;
  logic [STEP_W-1:0]  row;
  logic [STATE_W-1:0] ev;

  assign release_edge = now_ms - {{(TIME_W-DEB_W){1'b0}}, release_debounce_ms};
  assign row = qstate[STEP_W-1:0] & STEP_MASK;
  assign qstate_next = step_lookup(row, {left_pin, right_pin});
  assign ev = qstate_next & EVENT_MASK;

  always_comb begin
    held_next = held;
    hold_next = hold;
    last_press_next = last_press;
    if (!button_pin) begin
      if (held) begin
        hold_next = hold + (now_ms - last_press);
      end
      last_press_next = now_ms;
      held_next = 1'b1;
    end else if (held && (last_press < release_edge)) begin
      held_next = 1'b0;
      hold_next = '0;
    end
  end

  always_comb begin
    count_next = count;
    if (ev == EV_CW) begin
      count_next = count + 1'b1;
    end else if (ev == EV_CCW) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qstate <= ST_START;
      count <= '0;
      held <= 1'b0;
      last_press <= '0;
      hold <= '0;
    end else if (advance) begin
      qstate <= qstate_next;
      count <= count_next;
      held <= held_next;
      last_press <= last_press_next;
      hold <= hold_next;
    end
  end

  assign status_next = {count_next, held_next, hold_next};

endmodule

@@ sv/qreb_merge.sv @@
// Merge stage: packs the reported lanes into one result word.
`timescale 1ns / 1ps

module qreb_merge #(
  parameter int LANES = qreb_pkg::LANES_DEF
) (
  input  qreb_pkg::lane_status_t      lane_status [LANES],
  output logic [qreb_pkg::OUT_W-1:0]  word
);
  import qreb_pkg::*;

  logic [PIN_LANES-1:0][CNT_W-1:0]  counts;
  logic [PIN_LANES-1:0][TIME_W-1:0] holds;
  logic [PIN_LANES-1:0]             pressed;

  // Report the first four lanes; absent lanes read zero.
  for (genvar i = 0; i < PIN_LANES; i++) begin : g_out
    if (i < LANES) begin : g_have
      assign counts[i] = lane_status[i].count;
      assign holds[i] = lane_status[i].hold;
      assign pressed[i] = lane_status[i].held;
    end else begin : g_none
      assign counts[i] = '0;
      assign holds[i] = '0;
      assign pressed[i] = 1'b0;
    end
  end

  assign word = {{(OUT_W-OUT_USED_W){1'b0}}, holds, pressed, counts};

endmodule

@@ sv/quad_rotary_encoder_button_decoder.sv @@
// Top level: four-input encoder and button decoder with a two-word output buffer.
`timescale 1ns / 1ps

// An accepted word is registered onto m_tvalid/m_tdata if the output register is free, else into the skid word.
// Throughput: one word per cycle while no skid word waits; every lane steps its table and adders combinationally.
// A two-word output buffer lets one more word in while a result waits downstream.
// Reset (rst, synchronous, active high): lane state clears, the debounce register loads 50,
// and the output buffer empties. No clearing pass; input is taken the cycle after reset.
module quad_rotary_encoder_button_decoder #(
  parameter int LANES = qreb_pkg::LANES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [qreb_pkg::DEB_W-1:0]    cfg_wr_data,  // release_debounce_ms
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // right_pins[3:0], left_pins[7:4], button_pins[11:8], now_ms[43:12], zero pad
  input  logic [qreb_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // spin_count_0..3[63:0], pressed_mask[67:64], hold_time_0..3[195:68], zero pad
  output logic [qreb_pkg::OUT_W-1:0]    m_tdata
);
  import qreb_pkg::*;

  logic [DEB_W-1:0]     release_debounce_ms;
  logic                 accept;
  logic [PIN_LANES-1:0] right_pins, left_pins, button_pins;
  logic [TIME_W-1:0]    now_ms;
  lane_status_t         lane_status [LANES];
  logic [OUT_W-1:0]     result;
  logic                 skid_valid;
  logic [OUT_W-1:0]     skid_data;
  logic                 out_free;

  assign right_pins = s_tdata[IN_RIGHT_LSB +: PIN_LANES];
  assign left_pins = s_tdata[IN_LEFT_LSB +: PIN_LANES];
  assign button_pins = s_tdata[IN_BTN_LSB +: PIN_LANES];
  assign now_ms = s_tdata[IN_NOW_LSB +: TIME_W];

  assign s_tready = !skid_valid;
  assign accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      release_debounce_ms <= DEBOUNCE_RST;
    end else if (cfg_wr_en) begin
      release_debounce_ms <= cfg_wr_data;
    end
  end

  // Lanes past the pin fields see both quadrature pins high and the button released.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic r_pin, l_pin, b_pin;
    if (l < PIN_LANES) begin : g_pins
      assign r_pin = right_pins[l];
      assign l_pin = left_pins[l];
      assign b_pin = button_pins[l];
    end else begin : g_idle
      assign r_pin = 1'b1;
      assign l_pin = 1'b1;
      assign b_pin = 1'b1;
    end
    qreb_lane u_lane (
      .clk                 (clk),
      .rst                 (rst),
      .advance             (accept),
      .right_pin           (r_pin),
      .left_pin            (l_pin),
      .button_pin          (b_pin),
      .now_ms              (now_ms),
      .release_debounce_ms (release_debounce_ms),
      .status_next         (lane_status[l])
    );
  end

  qreb_merge #(.LANES(LANES)) u_merge (
    .lane_status (lane_status),
    .word        (result)
  );

  // Output register with a skid word behind it; the skid word always drains first.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= skid_valid || accept;
      skid_valid <= skid_valid && accept;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_tdata <= skid_valid ? skid_data : result;
      if (accept) begin
        skid_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

  property p_skid_needs_out;
    @(posedge clk) disable iff (rst) skid_valid |-> m_tvalid;
  endproperty
  a_skid_needs_out: assert property (p_skid_needs_out)
    else $error("skid word held while output register empty");

  property p_accept_fills;
    @(posedge clk) disable iff (rst) accept |=> m_tvalid;
  endproperty
  a_accept_fills: assert property (p_accept_fills)
    else $error("accepted word did not reach the output");

  property p_stall_keeps_skid;
    @(posedge clk) disable iff (rst) (skid_valid && m_tvalid && !m_tready) |=> skid_valid;
  endproperty
  a_stall_keeps_skid: assert property (p_stall_keeps_skid)
    else $error("skid word dropped during stall");

  property p_release_clears_hold;
    @(posedge clk) disable iff (rst)
      (m_tvalid && !m_tdata[OUT_MASK_LSB]) |-> (m_tdata[OUT_HOLD_LSB +: TIME_W] == '0);
  endproperty
  a_release_clears_hold: assert property (p_release_clears_hold)
    else $error("lane 0 hold time nonzero while not pressed");

endmodule

@@ bench/tb_quad_rotary_encoder_button_decoder.sv @@
// Self-checking bench for the four-lane encoder and button decoder, with a status scoreboard.
`timescale 1ns / 1ps

import qreb_pkg::*;

// Tracks every lane's table step, detent count and button state, and keeps the status
// words that the decoder still owes.
class status_scoreboard;
  logic [DEB_W-1:0]   debounce_ms;
  logic [STATE_W-1:0] step_state [PIN_LANES];
  logic [CNT_W-1:0]   detents [PIN_LANES];
  logic               held [PIN_LANES];
  logic [TIME_W-1:0]  press_stamp [PIN_LANES];
  logic [TIME_W-1:0]  hold_ms [PIN_LANES];
  logic [OUT_W-1:0]   expected_status [$];
  int errors;
  int checked;
  int cw_seen;
  int ccw_seen;
  int releases;

  function new();
    debounce_ms = DEBOUNCE_RST;
    for (int k = 0; k < PIN_LANES; k++) begin
      step_state[k] = ST_START;
      detents[k] = '0;
      held[k] = 1'b0;
      press_stamp[k] = '0;
      hold_ms[k] = '0;
    end
    errors = 0;
    checked = 0;
    cw_seen = 0;
    ccw_seen = 0;
    releases = 0;
  endfunction

  // Full-step table, one row per step, entries packed from pin state 3 down to 0.
  function logic [STATE_W-1:0] next_step(input logic [STEP_W-1:0] row, input logic [1:0] pin);
    logic [4*STATE_W-1:0] entries;
    case (row)
      4'd1: entries = {6'h10, 6'h01, 6'h00, 6'h03};
      4'd2: entries = {6'h00, 6'h00, 6'h02, 6'h03};
      4'd3: entries = {6'h00, 6'h01, 6'h02, 6'h03};
      4'd4: entries = {6'h00, 6'h04, 6'h00, 6'h06};
      4'd5: entries = {6'h20, 6'h00, 6'h05, 6'h06};
      4'd6: entries = {6'h00, 6'h04, 6'h05, 6'h06};
      // start row, also for any step value past the table
      default: entries = {6'h00, 6'h04, 6'h02, 6'h00};
    endcase
    return entries[pin*STATE_W +: STATE_W];
  endfunction

  function void note_sample(input logic [IN_W-1:0] w);
    logic [PIN_LANES-1:0] right, left, button;
    logic [TIME_W-1:0] now;
    logic [STATE_W-1:0] ev;
    logic [OUT_W-1:0] status;
    right = w[IN_RIGHT_LSB +: PIN_LANES];
    left = w[IN_LEFT_LSB +: PIN_LANES];
    button = w[IN_BTN_LSB +: PIN_LANES];
    now = w[IN_NOW_LSB +: TIME_W];
    status = '0;
    for (int k = 0; k < PIN_LANES; k++) begin
      if (!button[k]) begin
        if (held[k]) hold_ms[k] += now - press_stamp[k];
        press_stamp[k] = now;
        held[k] = 1'b1;
      end else if (held[k] && press_stamp[k] < now - {16'd0, debounce_ms}) begin
        held[k] = 1'b0;
        hold_ms[k] = '0;
        releases++;
      end
      step_state[k] = next_step(step_state[k][STEP_W-1:0] & STEP_MASK, {left[k], right[k]});
      ev = step_state[k] & EVENT_MASK;
      if (ev == EV_CW) begin
        detents[k] += 1'b1;
        cw_seen++;
      end else if (ev == EV_CCW) begin
        detents[k] -= 1'b1;
        ccw_seen++;
      end
      status[OUT_CNT_LSB + k*CNT_W +: CNT_W] = detents[k];
      status[OUT_MASK_LSB + k] = held[k];
      status[OUT_HOLD_LSB + k*TIME_W +: TIME_W] = hold_ms[k];
    end
    expected_status.push_back(status);
  endfunction

  function void check_status(input logic [OUT_W-1:0] got);
    logic [OUT_W-1:0] want;
    logic [CNT_W-1:0] want_cnt, got_cnt;
    logic [TIME_W-1:0] want_hold, got_hold;
    if (expected_status.size() == 0) begin
      $display("%0t: status word with nothing expected: %h", $time, got);
      errors++;
      return;
    end
    want = expected_status.pop_front();
    checked++;
    for (int k = 0; k < PIN_LANES; k++) begin
      want_cnt = want[OUT_CNT_LSB + k*CNT_W +: CNT_W];
      got_cnt = got[OUT_CNT_LSB + k*CNT_W +: CNT_W];
      if (got_cnt !== want_cnt) begin
        $display("%0t: spin_count_%0d expected %0d got %0d", $time, k,
                 $signed(want_cnt), $signed(got_cnt));
        errors++;
      end
      want_hold = want[OUT_HOLD_LSB + k*TIME_W +: TIME_W];
      got_hold = got[OUT_HOLD_LSB + k*TIME_W +: TIME_W];
      if (got_hold !== want_hold) begin
        $display("%0t: hold_time_%0d expected %0d got %0d", $time, k, want_hold, got_hold);
        errors++;
      end
    end
    if (got[OUT_MASK_LSB +: PIN_LANES] !== want[OUT_MASK_LSB +: PIN_LANES]) begin
      $display("%0t: pressed_mask expected %b got %b", $time,
               want[OUT_MASK_LSB +: PIN_LANES], got[OUT_MASK_LSB +: PIN_LANES]);
      errors++;
    end
  endfunction
endclass

module tb_quad_rotary_encoder_button_decoder;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [DEB_W-1:0] cfg_wr_data;
  logic s_tvalid;
  logic s_tready;
  logic [IN_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_W-1:0] m_tdata;

  status_scoreboard sb;
  bit steady_flow;
  logic [1:0] lane_pin [PIN_LANES];
  logic [PIN_LANES-1:0] button_level;
  logic [TIME_W-1:0] now_ms;

  quad_rotary_encoder_button_decoder DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("[quad_rotary_encoder_button_decoder] ERROR");
    $finish;
  end

  always @(negedge clk) begin
    m_tready = steady_flow || ($urandom_range(99) >= 37);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_status(m_tdata);
      if (s_tvalid && s_tready) sb.note_sample(s_tdata);
    end
  end

  function automatic logic [IN_W-1:0] pack_sample(input logic [3:0] right, input logic [3:0] left,
                                                  input logic [3:0] button,
                                                  input logic [TIME_W-1:0] now);
    logic [IN_W-1:0] w;
    w = '0;
    w[IN_RIGHT_LSB +: PIN_LANES] = right;
    w[IN_LEFT_LSB +: PIN_LANES] = left;
    w[IN_BTN_LSB +: PIN_LANES] = button;
    w[IN_NOW_LSB +: TIME_W] = now;
    return w;
  endfunction

  // Gray order of pin states for a clockwise turn: 3, 1, 0, 2, back to 3.
  function automatic logic [1:0] cw_pin(input logic [1:0] pin);
    case (pin)
      2'd3: return 2'd1;
      2'd1: return 2'd0;
      2'd0: return 2'd2;
      default: return 2'd3;
    endcase
  endfunction

  function automatic logic [1:0] ccw_pin(input logic [1:0] pin);
    case (pin)
      2'd3: return 2'd2;
      2'd2: return 2'd0;
      2'd0: return 2'd1;
      default: return 2'd3;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_sample(input logic [IN_W-1:0] w);
    while (!steady_flow && $urandom_range(99) < 37) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = w;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Mostly legal quadrature walks with slow buttons; a little noise on pins and buttons.
  task automatic send_random(input int count);
    logic [3:0] right, left, glitch;
    int roll;
    repeat (count) begin
      for (int k = 0; k < PIN_LANES; k++) begin
        roll = $urandom_range(99);
        if (roll < 5) lane_pin[k] = 2'($urandom_range(3));
        else if (roll < 35) lane_pin[k] = cw_pin(lane_pin[k]);
        else if (roll < 55) lane_pin[k] = ccw_pin(lane_pin[k]);
        right[k] = lane_pin[k][0];
        left[k] = lane_pin[k][1];
        if ($urandom_range(99) < 12) button_level[k] = ~button_level[k];
      end
      glitch = ($urandom_range(99) < 3) ? 4'($urandom_range(15)) : 4'h0;
      roll = $urandom_range(99);
      if (roll < 60) now_ms += $urandom_range(30);
      else if (roll < 85) now_ms += $urandom_range(400);
      else if (roll < 95) now_ms += $urandom_range(150000);
      else now_ms = $urandom;
      send_sample(pack_sample(right, left, button_level ^ glitch, now_ms));
    end
  endtask

  // Drop valid, wait for every owed status word, then write the debounce register.
  task automatic set_debounce(input logic [DEB_W-1:0] value);
    s_tvalid = 1'b0;
    while (sb.expected_status.size() != 0) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(posedge clk);
    sb.debounce_ms = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    steady_flow = 1'b0;
    button_level = 4'hF;
    now_ms = '0;
    for (int k = 0; k < PIN_LANES; k++) lane_pin[k] = 2'd3;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Full detents: clockwise on lanes 0 and 2, anticlockwise on 1 and 3, buttons 0 and 1 held.
    send_sample(pack_sample(4'hF, 4'hF, 4'hF, 32'd0));
    send_sample(pack_sample(4'h5, 4'hA, 4'hC, 32'd10));
    send_sample(pack_sample(4'h0, 4'h0, 4'hC, 32'd20));
    send_sample(pack_sample(4'hA, 4'h5, 4'hC, 32'd30));
    send_sample(pack_sample(4'hF, 4'hF, 4'hC, 32'd40));
    // Release: still held at exactly the debounce time, cleared one ms later.
    send_sample(pack_sample(4'hF, 4'hF, 4'hF, 32'd60));
    send_sample(pack_sample(4'hF, 4'hF, 4'hF, 32'd90));
    send_sample(pack_sample(4'hF, 4'hF, 4'hF, 32'd91));
    // Hold time wraps past 2^32, then a release where now minus debounce wraps.
    send_sample(pack_sample(4'hF, 4'hF, 4'hB, 32'h0000_0100));
    send_sample(pack_sample(4'hF, 4'hF, 4'hB, 32'hF000_0000));
    send_sample(pack_sample(4'hF, 4'hF, 4'hB, 32'h2000_0000));
    send_sample(pack_sample(4'hF, 4'hF, 4'hF, 32'h0000_0010));
    // Illegal jumps and field extremes.
    send_sample(pack_sample(4'h6, 4'h9, 4'h7, 32'h0000_1234));
    send_sample(pack_sample(4'h0, 4'h0, 4'h0, 32'hFFFF_FFFF));
    send_sample(pack_sample(4'hF, 4'hF, 4'h0, 32'hFFFF_FFFF));
    send_sample(pack_sample(4'hF, 4'h0, 4'hF, 32'h0000_0000));
    send_sample(pack_sample(4'h0, 4'hF, 4'hF, 32'h0000_0005));
    send_sample(pack_sample(4'hF, 4'hF, 4'hF, 32'h0001_0000));

    set_debounce(16'd0);
    send_sample(pack_sample(4'hF, 4'hF, 4'h7, 32'd100));
    send_sample(pack_sample(4'hF, 4'hF, 4'hF, 32'd100));
    send_sample(pack_sample(4'hF, 4'hF, 4'hF, 32'd101));
    send_random(240);

    // Widest debounce while neither side stalls; a small now releases at once.
    set_debounce(16'hFFFF);
    steady_flow = 1'b1;
    send_sample(pack_sample(4'hF, 4'hF, 4'hE, 32'd5));
    send_sample(pack_sample(4'hF, 4'hF, 4'hF, 32'd10));
    send_random(240);
    steady_flow = 1'b0;

    set_debounce(16'd1);
    send_random(240);
    set_debounce(16'($urandom_range(2, 65534)));
    send_random(240);
    set_debounce(DEBOUNCE_RST);
    send_random(240);

    s_tvalid = 1'b0;
    while (sb.expected_status.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    $display("checked %0d status words: %0d clockwise and %0d anticlockwise detents, %0d releases",
             sb.checked, sb.cw_seen, sb.ccw_seen, sb.releases);
    $display("debounce settings 50, 0, 65535, 1 and one random value, %0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("[quad_rotary_encoder_button_decoder] OK");
    end else begin
      $display("[quad_rotary_encoder_button_decoder] ERROR");
    end
    $finish;
  end

endmodule
